@@ src/gda_pkg.sv @@
package gda_pkg;

	localparam int IN_YEAR_W = 14;
	localparam int YEAR_W = 17;
	localparam int IDX_W = 26;
	localparam int DOY_W = 9;
	localparam int DAY_W = 5;
	localparam int MON_W = 4;
	localparam int OFF_W = 16;
	localparam int DIFF_W = 22;
	localparam int DEF_MAX_YEAR = 9999;
	localparam int DEF_OFFSET_BITS = 16;

	// floor(n * 400 / 146097) as (n * RECIP) >> 32
	localparam logic [23:0] YEAR_RECIP = 24'd11759221;
	localparam int YEAR_RECIP_SHIFT = 32;

	typedef enum logic [1:0] {
		MODE_ADD  = 2'd0,
		MODE_SUB  = 2'd1,
		MODE_DIFF = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// x / 100 by reciprocal, exact for x below 2**YEAR_W
	function automatic logic [10:0] div100(input logic [YEAR_W-1:0] x);
		logic [YEAR_W+17:0] prod;
		prod = x * 18'd167773;
		return prod[24 +: 11];
	endfunction

	function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [10:0] q);
		logic cent;
		cent = (y == YEAR_W'(q) * YEAR_W'(100));
		return ((y[1:0] == 2'd0) && !cent) || (cent && (q[1:0] == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic lp);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2: len = lp ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m, input logic lp);
		logic [DOY_W-1:0] s;
		unique case (m)
			4'd2: s = 9'd31;
			4'd3: s = 9'd59;
			4'd4: s = 9'd90;
			4'd5: s = 9'd120;
			4'd6: s = 9'd151;
			4'd7: s = 9'd181;
			4'd8: s = 9'd212;
			4'd9: s = 9'd243;
			4'd10: s = 9'd273;
			4'd11: s = 9'd304;
			4'd12: s = 9'd334;
			default: s = 9'd0;
		endcase
		return s + DOY_W'(lp && (m > 4'd2));
	endfunction

	// days from the first day of year 1 to the first day of year p + 1, q = p / 100
	function automatic logic [IDX_W-1:0] days_before(input logic [YEAR_W-1:0] p,
			input logic [10:0] q);
		return IDX_W'(p) * IDX_W'(365) + IDX_W'(p >> 2) - IDX_W'(q) + IDX_W'(q >> 2);
	endfunction

endpackage

@@ src/gda_date_index.sv @@
module gda_date_index #(
	parameter int MAX_YEAR = gda_pkg::DEF_MAX_YEAR
) (
	input  logic                           clk,
	input  logic [gda_pkg::DAY_W-1:0]      day,
	input  logic [gda_pkg::MON_W-1:0]      month,
	input  logic [gda_pkg::IN_YEAR_W-1:0]  year,
	output logic                           ok,
	output logic [gda_pkg::IDX_W-1:0]      idx
);

	localparam logic [gda_pkg::YEAR_W-1:0] MAX_Y = gda_pkg::YEAR_W'(MAX_YEAR);

	logic [gda_pkg::YEAR_W-1:0] y, p;
	logic [10:0] qy, qp;
	logic lp, valid;
	logic [gda_pkg::DOY_W-1:0] doy;

	logic ok_s1, ok_s2;
	logic [gda_pkg::YEAR_W-1:0] p_s1;
	logic [10:0] qp_s1;
	logic [gda_pkg::DOY_W-1:0] doy_s1;
	logic [gda_pkg::IDX_W-1:0] idx_s2;

	always_comb begin
		y = gda_pkg::YEAR_W'(year);
		p = y - 1'b1;
		qy = gda_pkg::div100(y);
		qp = gda_pkg::div100(p);
		lp = gda_pkg::is_leap(y, qy);
		valid = (y != '0) && (y <= MAX_Y) && (month >= 4'd1) && (month <= 4'd12)
			&& (day != '0) && (day <= gda_pkg::month_len(month, lp));
		doy = gda_pkg::month_start(month, lp) + gda_pkg::DOY_W'(day) - 1'b1;
	end

	always_ff @(posedge clk) begin
		ok_s1 <= valid;
		p_s1 <= p;
		qp_s1 <= qp;
		doy_s1 <= doy;
		ok_s2 <= ok_s1;
		idx_s2 <= gda_pkg::days_before(p_s1, qp_s1) + gda_pkg::IDX_W'(doy_s1);
	end

	assign ok = ok_s2;
	assign idx = idx_s2;

endmodule

@@ src/gda_index_date.sv @@
module gda_index_date (
	input  logic                        clk,
	input  logic [gda_pkg::IDX_W-1:0]   n,
	output logic [gda_pkg::DAY_W-1:0]   day,
	output logic [gda_pkg::MON_W-1:0]   month,
	output logic [gda_pkg::YEAR_W-1:0]  year
);

	localparam int PW = gda_pkg::IDX_W + 24;

	logic [PW-1:0] prod;
	logic [gda_pkg::IDX_W-1:0] n_s1, n_s2, n_s3;
	logic [gda_pkg::YEAR_W-1:0] y0_s1, y0_s2, y0_s3;
	logic [10:0] qa_s2, qb_s2, qc_s2;
	logic [gda_pkg::IDX_W-1:0] dby0_s3;
	logic lplo_s3, lpmid_s3, lphi_s3;
	logic [gda_pkg::DOY_W-1:0] rem_s4;
	logic [gda_pkg::YEAR_W-1:0] yr_s4;
	logic lp_s4;
	logic [gda_pkg::DAY_W-1:0] day_s5;
	logic [gda_pkg::MON_W-1:0] month_s5;
	logic [gda_pkg::YEAR_W-1:0] year_s5;

	logic [gda_pkg::IDX_W-1:0] dby1, dbym;
	logic [gda_pkg::DOY_W-1:0] rem4;
	logic [gda_pkg::YEAR_W-1:0] yr4;
	logic lp4;
	logic [gda_pkg::MON_W-1:0] mon5;
	logic [gda_pkg::DOY_W-1:0] st5;

	assign prod = n * gda_pkg::YEAR_RECIP;

	// estimate lands within one year of the answer; correct it in stage four
	always_comb begin
		dby1 = dby0_s3 + gda_pkg::IDX_W'(365) + gda_pkg::IDX_W'(lpmid_s3);
		dbym = dby0_s3 - gda_pkg::IDX_W'(365) - gda_pkg::IDX_W'(lplo_s3);
		priority if (n_s3 < dby0_s3) begin
			yr4 = y0_s3 - 1'b1;
			rem4 = gda_pkg::DOY_W'(n_s3 - dbym);
			lp4 = lplo_s3;
		end else if (n_s3 >= dby1) begin
			yr4 = y0_s3 + 1'b1;
			rem4 = gda_pkg::DOY_W'(n_s3 - dby1);
			lp4 = lphi_s3;
		end else begin
			yr4 = y0_s3;
			rem4 = gda_pkg::DOY_W'(n_s3 - dby0_s3);
			lp4 = lpmid_s3;
		end
	end

	always_comb begin
		mon5 = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (rem_s4 >= gda_pkg::month_start(gda_pkg::MON_W'(k), lp_s4))
				mon5 = gda_pkg::MON_W'(k);
		end
		st5 = gda_pkg::month_start(mon5, lp_s4);
	end

	always_ff @(posedge clk) begin
		n_s1 <= n;
		y0_s1 <= prod[gda_pkg::YEAR_RECIP_SHIFT +: gda_pkg::YEAR_W] + 1'b1;

		n_s2 <= n_s1;
		y0_s2 <= y0_s1;
		qa_s2 <= gda_pkg::div100(y0_s1 - 1'b1);
		qb_s2 <= gda_pkg::div100(y0_s1);
		qc_s2 <= gda_pkg::div100(y0_s1 + 1'b1);

		n_s3 <= n_s2;
		y0_s3 <= y0_s2;
		dby0_s3 <= gda_pkg::days_before(y0_s2 - 1'b1, qa_s2);
		lplo_s3 <= gda_pkg::is_leap(y0_s2 - 1'b1, qa_s2);
		lpmid_s3 <= gda_pkg::is_leap(y0_s2, qb_s2);
		lphi_s3 <= gda_pkg::is_leap(y0_s2 + 1'b1, qc_s2);

		rem_s4 <= rem4;
		yr_s4 <= yr4;
		lp_s4 <= lp4;

		month_s5 <= mon5;
		day_s5 <= gda_pkg::DAY_W'(rem_s4 - st5 + 1'b1);
		year_s5 <= yr_s4;
	end

	assign day = day_s5;
	assign month = month_s5;
	assign year = year_s5;

endmodule

@@ src/gregorian_date_arithmetic_top.sv @@
// Gregorian date arithmetic: add or subtract a day count, or take the distance
// between two dates. Raise start for one cycle with the request on the input
// ports; busy stays low, so a new request may be issued in every cycle. The
// answer comes back exactly eight cycles later with done high for one cycle
// and must be captured then, since the receiver cannot stall the unit. The
// latency is fixed by an eight-stage pipeline: two stages map each date to a
// day count since the first day of year 1, one stage does the add, subtract
// or compare, and five stages turn the day count back into a date (a
// reciprocal multiply estimates the year, one step fixes it, a table of month
// starts picks month and day). Status 2 flags an invalid date or mode 3,
// status 1 a result outside years 1 to MAX_YEAR or a saturated difference.
module gregorian_date_arithmetic_top #(
	parameter int MAX_YEAR = gda_pkg::DEF_MAX_YEAR,
	parameter int OFFSET_BITS = gda_pkg::DEF_OFFSET_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic [1:0]                     mode,
	input  logic [gda_pkg::DAY_W-1:0]      first_day,
	input  logic [gda_pkg::MON_W-1:0]      first_month,
	input  logic [gda_pkg::IN_YEAR_W-1:0]  first_year,
	input  logic [gda_pkg::OFF_W-1:0]      day_offset,
	input  logic [gda_pkg::DAY_W-1:0]      second_day,
	input  logic [gda_pkg::MON_W-1:0]      second_month,
	input  logic [gda_pkg::IN_YEAR_W-1:0]  second_year,
	output logic [gda_pkg::DAY_W-1:0]      result_day,
	output logic [gda_pkg::MON_W-1:0]      result_month,
	output logic [gda_pkg::IN_YEAR_W-1:0]  result_year,
	output logic [gda_pkg::DIFF_W-1:0]     day_difference,
	output logic                           first_earlier,
	output logic                           dates_equal,
	output logic [1:0]                     status
);

	localparam int IW = gda_pkg::IDX_W;
	// day count of the first day after the last representable year
	localparam int DBY_END = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
	localparam logic [gda_pkg::OFF_W-1:0] OFF_MASK =
		gda_pkg::OFF_W'((64'd1 << OFFSET_BITS) - 64'd1);
	localparam logic [IW-1:0] DIFF_MAX = IW'((64'd1 << gda_pkg::DIFF_W) - 64'd1);

	typedef struct packed {
		logic                          use_date;
		gda_pkg::status_t              status;
		logic [gda_pkg::DIFF_W-1:0]    diff;
		logic                          earlier;
		logic                          equal;
	} side_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	gda_pkg::mode_t mode_s1, mode_s2;
	logic [gda_pkg::OFF_W-1:0] off_s1, off_s2;
	side_t side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [IW-1:0] n_s3;

	logic ok_a, ok_b;
	logic [IW-1:0] idx_a, idx_b;
	side_t side3;
	logic [IW-1:0] n3, day_span;
	logic [gda_pkg::DAY_W-1:0] rd;
	logic [gda_pkg::MON_W-1:0] rm;
	logic [gda_pkg::YEAR_W-1:0] ry;

	// the pipeline never stalls
	assign busy = 1'b0;

	gda_date_index #(.MAX_YEAR(MAX_YEAR)) u_first (
		.clk(clk), .day(first_day), .month(first_month), .year(first_year),
		.ok(ok_a), .idx(idx_a)
	);

	gda_date_index #(.MAX_YEAR(MAX_YEAR)) u_second (
		.clk(clk), .day(second_day), .month(second_month), .year(second_year),
		.ok(ok_b), .idx(idx_b)
	);

	// stage three: pick the operation, check ranges, fix the status
	always_comb begin
		side3 = '0;
		n3 = '0;
		day_span = (idx_a < idx_b) ? idx_b - idx_a : idx_a - idx_b;
		if (mode_s2 == gda_pkg::MODE_RSVD || !ok_a || (mode_s2 == gda_pkg::MODE_DIFF && !ok_b)) begin
			side3.status = gda_pkg::ST_INVALID;
		end else begin
			unique case (mode_s2)
				gda_pkg::MODE_DIFF: begin
					side3.earlier = idx_a < idx_b;
					side3.equal = idx_a == idx_b;
					if (day_span > DIFF_MAX) begin
						side3.diff = '1;
						side3.status = gda_pkg::ST_RANGE;
					end else begin
						side3.diff = gda_pkg::DIFF_W'(day_span);
					end
				end
				gda_pkg::MODE_ADD: begin
					n3 = idx_a + IW'(off_s2);
					if (n3 >= IW'(DBY_END))
						side3.status = gda_pkg::ST_RANGE;
					else
						side3.use_date = 1'b1;
				end
				default: begin
					n3 = idx_a - IW'(off_s2);
					if (IW'(off_s2) > idx_a)
						side3.status = gda_pkg::ST_RANGE;
					else
						side3.use_date = 1'b1;
				end
			endcase
		end
	end

	gda_index_date u_conv (
		.clk(clk), .n(n_s3), .day(rd), .month(rm), .year(ry)
	);

	// advance the valid bits; a transfer enters on start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// hold request side data alongside the date converters
	always_ff @(posedge clk) begin
		mode_s1 <= gda_pkg::mode_t'(mode);
		off_s1 <= day_offset & OFF_MASK;
		mode_s2 <= mode_s1;
		off_s2 <= off_s1;
		side_s3 <= side3;
		n_s3 <= n3;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
		side_s8 <= side_s7;
	end

	// drop the date fields unless the answer is a valid date
	assign done = vld_s8;
	assign result_day = side_s8.use_date ? rd : '0;
	assign result_month = side_s8.use_date ? rm : '0;
	assign result_year = side_s8.use_date ? ry[gda_pkg::IN_YEAR_W-1:0] : '0;
	assign day_difference = side_s8.diff;
	assign first_earlier = side_s8.earlier;
	assign dates_equal = side_s8.equal;
	assign status = side_s8.status;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done)
		else $error("result strobe missing eight cycles after request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3))
		else $error("unused status code");

	a_error_clears_date: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != gda_pkg::ST_OK) |-> (result_day == '0 && result_month == '0
			&& result_year == '0))
		else $error("date fields set on error");

	a_equal_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dates_equal) |-> (day_difference == '0 && !first_earlier))
		else $error("equal dates with nonzero distance");

endmodule

@@ dv/date_checker.sv @@
`timescale 1ns / 100ps

module date_checker
	import gda_pkg::*;
#(
	parameter int MAX_YR = 9999,
	parameter int OFF_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic                   done,
	input  logic [1:0]             mode,
	input  logic [DAY_W-1:0]       first_day,
	input  logic [MON_W-1:0]       first_month,
	input  logic [IN_YEAR_W-1:0]   first_year,
	input  logic [OFF_W-1:0]       day_offset,
	input  logic [DAY_W-1:0]       second_day,
	input  logic [MON_W-1:0]       second_month,
	input  logic [IN_YEAR_W-1:0]   second_year,
	input  logic [DAY_W-1:0]       result_day,
	input  logic [MON_W-1:0]       result_month,
	input  logic [IN_YEAR_W-1:0]   result_year,
	input  logic [DIFF_W-1:0]      day_difference,
	input  logic                   first_earlier,
	input  logic                   dates_equal,
	input  logic [1:0]             status,
	output int                     fail_count,
	output int                     pending
);

	typedef struct packed {
		logic [DAY_W-1:0]     rday;
		logic [MON_W-1:0]     rmon;
		logic [IN_YEAR_W-1:0] ryear;
		logic [DIFF_W-1:0]    diff;
		logic                 earlier;
		logic                 equal;
		status_t              st;
	} date_answer_t;

	date_answer_t answer_q[$];

	function automatic bit leap_year(longint y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic longint month_days(longint m, longint y);
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic longint year_start(longint y);
		longint p;
		p = y - 1;
		return 365 * p + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic bit good_date(longint d, longint m, longint y);
		if (y < 1 || y > MAX_YR || m < 1 || m > 12) return 0;
		return d >= 1 && d <= month_days(m, y);
	endfunction

	function automatic longint day_number(longint d, longint m, longint y);
		longint n;
		n = year_start(y);
		for (longint k = 1; k < m; k++) n += month_days(k, y);
		return n + d - 1;
	endfunction

	function automatic date_answer_t compute_answer();
		date_answer_t r;
		longint a, b, n, off, yr, mo;
		r = '0;
		r.st = ST_OK;
		off = day_offset & ((64'd1 << OFF_BITS) - 1);
		if (mode_t'(mode) == MODE_RSVD || !good_date(first_day, first_month, first_year)) begin
			r.st = ST_INVALID;
			return r;
		end
		a = day_number(first_day, first_month, first_year);
		if (mode_t'(mode) == MODE_DIFF) begin
			if (!good_date(second_day, second_month, second_year)) begin
				r.st = ST_INVALID;
				return r;
			end
			b = day_number(second_day, second_month, second_year);
			n = (a < b) ? b - a : a - b;
			r.earlier = a < b;
			r.equal = a == b;
			if (n > (1 << DIFF_W) - 1) begin
				n = (1 << DIFF_W) - 1;
				r.st = ST_RANGE;
			end
			r.diff = DIFF_W'(n);
			return r;
		end
		if (mode_t'(mode) == MODE_ADD) begin
			n = a + off;
			if (n >= year_start(MAX_YR + 1)) begin
				r.st = ST_RANGE;
				return r;
			end
		end else begin
			if (off > a) begin
				r.st = ST_RANGE;
				return r;
			end
			n = a - off;
		end
		// walk to the year, then the month
		yr = (n * 400) / 146097 + 1;
		while (year_start(yr + 1) <= n) yr++;
		while (yr > 1 && year_start(yr) > n) yr--;
		n -= year_start(yr);
		mo = 1;
		while (mo < 12 && n >= month_days(mo, yr)) begin
			n -= month_days(mo, yr);
			mo++;
		end
		r.rday = DAY_W'(n + 1);
		r.rmon = MON_W'(mo);
		r.ryear = IN_YEAR_W'(yr);
		return r;
	endfunction

	initial fail_count = 0;

	// predict on each accepted transfer, compare on each done
	always @(posedge clk) begin
		date_answer_t exp_a;
		if (arst_n) begin
			if (done) begin
				if (answer_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					exp_a = answer_q.pop_front();
					if (result_day !== exp_a.rday) begin
						$error("result_day exp %0d got %0d", exp_a.rday, result_day);
						fail_count++;
					end
					if (result_month !== exp_a.rmon) begin
						$error("result_month exp %0d got %0d", exp_a.rmon, result_month);
						fail_count++;
					end
					if (result_year !== exp_a.ryear) begin
						$error("result_year exp %0d got %0d", exp_a.ryear, result_year);
						fail_count++;
					end
					if (day_difference !== exp_a.diff) begin
						$error("day_difference exp %0d got %0d", exp_a.diff, day_difference);
						fail_count++;
					end
					if (first_earlier !== exp_a.earlier) begin
						$error("first_earlier exp %0d got %0d", exp_a.earlier, first_earlier);
						fail_count++;
					end
					if (dates_equal !== exp_a.equal) begin
						$error("dates_equal exp %0d got %0d", exp_a.equal, dates_equal);
						fail_count++;
					end
					if (status !== exp_a.st) begin
						$error("status exp %0d got %0d", exp_a.st, status);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				answer_q.push_back(compute_answer());
		end
		pending = answer_q.size();
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import gda_pkg::*;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 start = 0;
	logic                 busy, done;
	logic [1:0]           mode = 0;
	logic [DAY_W-1:0]     first_day = 1;
	logic [MON_W-1:0]     first_month = 1;
	logic [IN_YEAR_W-1:0] first_year = 1;
	logic [OFF_W-1:0]     day_offset = 0;
	logic [DAY_W-1:0]     second_day = 1;
	logic [MON_W-1:0]     second_month = 1;
	logic [IN_YEAR_W-1:0] second_year = 1;
	logic [DAY_W-1:0]     result_day;
	logic [MON_W-1:0]     result_month;
	logic [IN_YEAR_W-1:0] result_year;
	logic [DIFF_W-1:0]    day_difference;
	logic                 first_earlier, dates_equal;
	logic [1:0]           status;
	int                   fail_count, pending;

	always #5 clk = ~clk;

	gregorian_date_arithmetic_top dut (.*);

	date_checker checker_i (.*);

	// pick a year: mostly ordinary, sometimes edges or any 14-bit value
	function automatic logic [IN_YEAR_W-1:0] pick_year();
		case ($urandom_range(0, 9))
			0: return IN_YEAR_W'($urandom_range(1, 3));
			1: return IN_YEAR_W'($urandom_range(9995, 9999));
			2: return IN_YEAR_W'($urandom);
			3: return IN_YEAR_W'(400 * $urandom_range(1, 24) + $urandom_range(0, 1) * 100);
			default: return IN_YEAR_W'($urandom_range(1, 9999));
		endcase
	endfunction

	function automatic logic [DAY_W-1:0] pick_day();
		if ($urandom_range(0, 9) == 0) return DAY_W'($urandom);
		if ($urandom_range(0, 3) == 0) return DAY_W'($urandom_range(27, 31));
		return DAY_W'($urandom_range(1, 28));
	endfunction

	function automatic logic [MON_W-1:0] pick_month();
		if ($urandom_range(0, 14) == 0) return MON_W'($urandom);
		if ($urandom_range(0, 3) == 0) return 2;
		return MON_W'($urandom_range(1, 12));
	endfunction

	// present one request and hold it until the transfer; start stays high
	// into a following request that has no gap
	task automatic send(logic [1:0] m, logic [DAY_W-1:0] d1, logic [MON_W-1:0] m1,
			logic [IN_YEAR_W-1:0] y1, logic [OFF_W-1:0] off,
			logic [DAY_W-1:0] d2, logic [MON_W-1:0] m2, logic [IN_YEAR_W-1:0] y2);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		mode <= m;
		first_day <= d1;
		first_month <= m1;
		first_year <= y1;
		day_offset <= off;
		second_day <= d2;
		second_month <= m2;
		second_year <= y2;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [1:0] m;
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: extremes, leap days, range errors, invalid dates, reserved mode
		send(MODE_ADD, 1, 1, 1, 0, 1, 1, 1);
		send(MODE_ADD, 31, 12, 9999, 1, 1, 1, 1);
		send(MODE_ADD, 28, 2, 2024, 1, 1, 1, 1);
		send(MODE_ADD, 28, 2, 1900, 1, 1, 1, 1);
		send(MODE_ADD, 28, 2, 2000, 1, 1, 1, 1);
		send(MODE_ADD, 1, 1, 9900, 16'hFFFF, 1, 1, 1);
		send(MODE_ADD, 31, 12, 1999, 16'hFFFF, 1, 1, 1);
		send(MODE_SUB, 1, 1, 1, 1, 1, 1, 1);
		send(MODE_SUB, 1, 1, 1, 0, 1, 1, 1);
		send(MODE_SUB, 1, 3, 2024, 1, 1, 1, 1);
		send(MODE_SUB, 31, 12, 9999, 16'hFFFF, 1, 1, 1);
		send(MODE_SUB, 1, 1, 100, 16'hFFFF, 1, 1, 1);
		send(MODE_DIFF, 1, 1, 1, 0, 31, 12, 9999);
		send(MODE_DIFF, 31, 12, 9999, 0, 1, 1, 1);
		send(MODE_DIFF, 15, 6, 2020, 0, 15, 6, 2020);
		send(MODE_DIFF, 29, 2, 2023, 0, 1, 1, 1);
		send(MODE_DIFF, 1, 1, 1, 0, 31, 4, 2000);
		send(MODE_DIFF, 1, 13, 2000, 0, 1, 1, 1);
		send(MODE_ADD, 0, 1, 2000, 5, 1, 1, 1);
		send(MODE_ADD, 1, 0, 2000, 5, 1, 1, 1);
		send(MODE_ADD, 1, 1, 0, 5, 1, 1, 1);
		send(MODE_SUB, 1, 1, 16383, 5, 31, 15, 16383);
		send(MODE_ADD, 31, 15, 16383, 5, 0, 0, 0);
		send(MODE_RSVD, 1, 1, 2000, 5, 1, 1, 2000);
		for (int i = 0; i < 1250; i++) begin
			m = ($urandom_range(0, 19) == 0) ? MODE_RSVD : 2'($urandom_range(0, 2));
			send(m, pick_day(), pick_month(), pick_year(),
				OFF_W'(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 400)),
				pick_day(), pick_month(), pick_year());
		end
		start <= 0;
		// drain the pipeline, then let trailing cycles show any stray done
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// stop a hung run
	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
src/gda_pkg.sv
src/gda_date_index.sv
src/gda_index_date.sv
src/gregorian_date_arithmetic_top.sv
dv/date_checker.sv
dv/testbench.sv
